// ===== rtl/bps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package bps_pkg;

	typedef enum logic [1:0] {
		PAT_SILENT   = 2'd0,
		PAT_START    = 2'd1,
		PAT_OBSTACLE = 2'd2,
		PAT_FAULT    = 2'd3
	} pattern_t;

	typedef enum logic {
		FUNC_SET    = 1'b0,
		FUNC_UPDATE = 1'b1
	} func_t;

	localparam int DurW = 11;

	typedef struct packed {
		pattern_t    requested;
		logic        obstacle_latched;
		pattern_t    playing;
		logic [1:0]  position;
		logic [31:0] start_time;
		logic        pin;
	} seq_state_t;

	function automatic logic [2:0] step_count(input pattern_t pat);
		logic [2:0] cnt;
		begin
			case (pat)
				PAT_START:    cnt = 3'd2;
				PAT_OBSTACLE: cnt = 3'd4;
				PAT_FAULT:    cnt = 3'd2;
				default:      cnt = 3'd0;
			endcase
			return cnt;
		end
	endfunction

	function automatic logic [DurW-1:0] step_dur(input pattern_t pat, input logic [1:0] idx);
		logic [DurW-1:0] dur;
		begin
			dur = '0;
			case (pat)
				PAT_START: begin
					if (idx == 2'd0) dur = 11'd100;
					else if (idx == 2'd1) dur = 11'd1900;
				end
				PAT_OBSTACLE: begin
					if (idx == 2'd3) dur = 11'd700;
					else dur = 11'd100;
				end
				PAT_FAULT: begin
					if (idx == 2'd0 || idx == 2'd1) dur = 11'd200;
				end
				default: dur = '0;
			endcase
			return dur;
		end
	endfunction

	function automatic logic step_on(input pattern_t pat, input logic [1:0] idx);
		logic on;
		begin
			case (pat)
				PAT_START:    on = (idx == 2'd0);
				PAT_OBSTACLE: on = (idx == 2'd0) || (idx == 2'd2);
				PAT_FAULT:    on = (idx == 2'd0);
				default:      on = 1'b0;
			endcase
			return on;
		end
	endfunction

endpackage
`default_nettype wire

// ===== rtl/buzzer_pattern_sequencer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake               Contents
// in        input      in_valid / in_stall     func, pattern_request, now_ms
// out       output     out_valid / out_stall   pin_written, pin_level
// cfg       input      cfg_valid / cfg_ready   drive_polarity_high
//
// One word is taken every cycle unless the input is stalled.
// Each result passes through the input register, the step logic and the result register.
// Reset clears the sequencer to silent with the pin at level 0 and polarity high.
// A stalled output holds its word and stalls the input once the input register is full.
module buzzer_pattern_sequencer_core (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_stall,
	input  wire        func,
	input  wire [1:0]  pattern_request,
	input  wire [31:0] now_ms,
	output logic       out_valid,
	input  wire        out_stall,
	output logic       pin_written,
	output logic       pin_level,
	input  wire        cfg_valid,
	output logic       cfg_ready,
	input  wire        drive_polarity_high
);

	logic                valid_s1;
	logic                func_s1;
	logic [1:0]          req_s1;
	logic [31:0]         now_s1;
	logic                polarity_q;
	logic                advance;
	logic                written;
	bps_pkg::seq_state_t state_q;
	bps_pkg::seq_state_t state_next;

	assign cfg_ready = 1'b1;
	assign advance = !out_valid || !out_stall;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			polarity_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			polarity_q <= drive_polarity_high;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			func_s1 <= func;
			req_s1 <= pattern_request;
			now_s1 <= now_ms;
		end
	end

	bps_step u_step (
		.cur             (state_q),
		.func            (func_s1),
		.pattern_request (req_s1),
		.now_ms          (now_s1),
		.polarity        (polarity_q),
		.nxt             (state_next),
		.written         (written)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{requested: bps_pkg::PAT_SILENT, obstacle_latched: 1'b0,
				playing: bps_pkg::PAT_SILENT, position: 2'd0, start_time: 32'd0, pin: 1'b0};
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= valid_s1;
			if (valid_s1) begin
				state_q <= state_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			pin_written <= written;
			pin_level <= state_next.pin;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/bps_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bps_step (
	input  wire bps_pkg::seq_state_t cur,
	input  wire                      func,
	input  wire [1:0]                pattern_request,
	input  wire [31:0]               now_ms,
	input  wire                      polarity,
	output bps_pkg::seq_state_t      nxt,
	output logic                     written
);

	bps_pkg::pattern_t req;
	bps_pkg::pattern_t begin_pat;
	logic              preempt;
	logic              change;
	logic [2:0]        cnt;
	logic [31:0]       elapsed;
	logic [bps_pkg::DurW-1:0] dur;
	logic              step_done;
	logic [1:0]        idx_next;
	logic [1:0]        cnt_mask;

	assign req = bps_pkg::pattern_t'(pattern_request);
	assign begin_pat = cur.obstacle_latched ? bps_pkg::PAT_OBSTACLE : cur.requested;
	assign preempt = (cur.requested == bps_pkg::PAT_FAULT || cur.requested == bps_pkg::PAT_SILENT)
		&& (cur.requested != cur.playing);
	assign change = (cur.playing != bps_pkg::PAT_OBSTACLE)
		&& (cur.obstacle_latched || (cur.requested != cur.playing));
	assign cnt = bps_pkg::step_count(cur.playing);
	assign cnt_mask = cnt[1:0] - 2'd1;
	assign elapsed = now_ms - cur.start_time;
	assign dur = bps_pkg::step_dur(cur.playing, cur.position);
	assign step_done = elapsed >= {{(32-bps_pkg::DurW){1'b0}}, dur};
	assign idx_next = (cur.position + 2'd1) & cnt_mask;

	always_comb begin
		nxt = cur;
		written = 1'b0;
		if (func == bps_pkg::FUNC_SET) begin
			if (req == bps_pkg::PAT_OBSTACLE && cur.requested != bps_pkg::PAT_OBSTACLE) begin
				nxt.obstacle_latched = 1'b1;
			end
			if (req == bps_pkg::PAT_FAULT || req == bps_pkg::PAT_SILENT) begin
				nxt.obstacle_latched = 1'b0;
			end
			nxt.requested = req;
		end else begin
			if (preempt || change || (step_done && cnt != 3'd0
					&& cur.playing == bps_pkg::PAT_OBSTACLE && cur.position == 2'd3)) begin
				nxt.playing = begin_pat;
				nxt.obstacle_latched = 1'b0;
				nxt.position = 2'd0;
				nxt.start_time = now_ms;
				nxt.pin = bps_pkg::step_on(begin_pat, 2'd0) ? polarity : ~polarity;
				written = 1'b1;
			end else if (cnt == 3'd0) begin
				nxt.pin = ~polarity;
				written = 1'b1;
			end else if (step_done) begin
				nxt.start_time = cur.start_time + {{(32-bps_pkg::DurW){1'b0}}, dur};
				nxt.position = idx_next;
				nxt.pin = bps_pkg::step_on(cur.playing, idx_next) ? polarity : ~polarity;
				written = 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/bps_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bps_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       in_valid,
	input wire       in_stall,
	input wire       func,
	input wire       out_valid,
	input wire       out_stall,
	input wire       pin_written,
	input wire       pin_level
);

	// A stalled result word keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pin_written) && $stable(pin_level))
		else $error("result word changed while stalled");

	// A word accepted with the output free comes out through both registers if the output stays free.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && !out_stall) ##1 !out_stall |=> out_valid)
		else $error("result missing after accepted word");

	// A set word never drives the pin.
	a_set_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && !func && !out_stall) ##1 !out_stall |=>
		out_valid && !pin_written)
		else $error("set word reported a pin drive");

endmodule

bind buzzer_pattern_sequencer_core bps_checker u_bps_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.func        (func),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.pin_written (pin_written),
	.pin_level   (pin_level)
);
`default_nettype wire

// ===== sim/tb_buzzer_pattern_sequencer_core.sv =====
`timescale 1ns / 1ps

module tb_buzzer_pattern_sequencer_core;

	typedef struct {
		bps_pkg::func_t    op;
		bps_pkg::pattern_t req;
		logic [31:0]       stamp;
	} buzz_item_t;

	typedef struct {
		logic written;
		logic level;
	} pin_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        func = 1'b0;
	logic [1:0]  pattern_request = 2'd0;
	logic [31:0] now_ms = 32'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        pin_written;
	logic        pin_level;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        drive_polarity_high = 1'b1;

	buzz_item_t  item_backlog[$];
	pin_word_t   pin_forecast[$];

	// Predictor state.
	logic              polarity;
	bps_pkg::pattern_t want_pat;
	logic              obstacle_armed;
	bps_pkg::pattern_t tune_pat;
	logic [1:0]        tune_step;
	logic [31:0]       tune_t0;
	logic              pin_held;

	logic        in_took = 1'b0;
	logic        offering = 1'b0;
	logic        quiet = 1'b0;
	int          send_gap = 0;
	int          hold_serial = 0;
	int          hold_seen = 0;
	int          hold_left = 0;
	int          run_left = 0;
	int          errors = 0;
	int          words_in = 0;
	int          words_out = 0;
	int          drives = 0;
	int          polarity_writes = 0;
	logic [31:0] stim_ms;

	buzzer_pattern_sequencer_core dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (in_valid),
		.in_stall            (in_stall),
		.func                (func),
		.pattern_request     (pattern_request),
		.now_ms              (now_ms),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.pin_written         (pin_written),
		.pin_level           (pin_level),
		.cfg_valid           (cfg_valid),
		.cfg_ready           (cfg_ready),
		.drive_polarity_high (drive_polarity_high)
	);

	always #10 clk = ~clk;

	function automatic logic [2:0] beep_steps(bps_pkg::pattern_t p);
		case (p)
			bps_pkg::PAT_START:    return 3'd2;
			bps_pkg::PAT_OBSTACLE: return 3'd4;
			bps_pkg::PAT_FAULT:    return 3'd2;
			default:               return 3'd0;
		endcase
	endfunction

	function automatic logic [31:0] beep_len(bps_pkg::pattern_t p, logic [1:0] s);
		case (p)
			bps_pkg::PAT_START:
				return (s == 2'd0) ? 32'd100 : (s == 2'd1) ? 32'd1900 : 32'd0;
			bps_pkg::PAT_OBSTACLE: return (s == 2'd3) ? 32'd700 : 32'd100;
			bps_pkg::PAT_FAULT:    return (s <= 2'd1) ? 32'd200 : 32'd0;
			default:               return 32'd0;
		endcase
	endfunction

	function automatic logic beep_on(bps_pkg::pattern_t p, logic [1:0] s);
		return (p != bps_pkg::PAT_SILENT)
			&& ((s == 2'd0) || (p == bps_pkg::PAT_OBSTACLE && s == 2'd2));
	endfunction

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (quiet || roll < 60)
			return 0;
		else if (roll < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 30);
	endfunction

	function automatic logic [31:0] ms_step();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll < 6)
			return $urandom_range(0, 220);
		else if (roll < 8)
			return $urandom_range(600, 800);
		else
			return $urandom_range(1800, 2100);
	endfunction

	task automatic sound_pin(input logic on);
		pin_held = on ? polarity : ~polarity;
	endtask

	task automatic start_tune(input logic [31:0] stamp);
		tune_pat = obstacle_armed ? bps_pkg::PAT_OBSTACLE : want_pat;
		obstacle_armed = 1'b0;
		tune_step = 2'd0;
		tune_t0 = stamp;
		sound_pin(beep_steps(tune_pat) != 3'd0 && beep_on(tune_pat, 2'd0));
	endtask

	task automatic step_buzzer(input bps_pkg::func_t op, input bps_pkg::pattern_t req,
			input logic [31:0] stamp, output pin_word_t res);
		logic       preempt;
		logic       change;
		logic [2:0] cnt;
		logic [1:0] nxt;
		res.written = 1'b0;
		if (op == bps_pkg::FUNC_SET) begin
			if (req == bps_pkg::PAT_OBSTACLE && want_pat != bps_pkg::PAT_OBSTACLE)
				obstacle_armed = 1'b1;
			if (req == bps_pkg::PAT_FAULT || req == bps_pkg::PAT_SILENT)
				obstacle_armed = 1'b0;
			want_pat = req;
		end else begin
			cnt = beep_steps(tune_pat);
			preempt = (want_pat == bps_pkg::PAT_FAULT || want_pat == bps_pkg::PAT_SILENT)
				&& want_pat != tune_pat;
			change = tune_pat != bps_pkg::PAT_OBSTACLE
				&& (obstacle_armed || want_pat != tune_pat);
			if (preempt || change) begin
				start_tune(stamp);
				res.written = 1'b1;
			end else if (cnt == 3'd0) begin
				sound_pin(1'b0);
				res.written = 1'b1;
			end else if (stamp - tune_t0 >= beep_len(tune_pat, tune_step)) begin
				if (tune_pat == bps_pkg::PAT_OBSTACLE && tune_step == 2'd3) begin
					start_tune(stamp);
				end else begin
					tune_t0 = tune_t0 + beep_len(tune_pat, tune_step);
					nxt = tune_step + 2'd1;
					if (cnt == 3'd2)
						nxt[1] = 1'b0;
					tune_step = nxt;
					sound_pin(beep_on(tune_pat, nxt));
				end
				res.written = 1'b1;
			end
		end
		res.level = pin_held;
	endtask

	task automatic flag_mismatch(input string what, input int got, input int want);
		if (errors < 100)
			$display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		pin_word_t res;
		pin_word_t exp;
		if (arst_n) begin
			in_took <= in_valid && !in_stall;
			if (cfg_valid && cfg_ready) begin
				polarity = drive_polarity_high;
				polarity_writes++;
			end
			if (in_valid && !in_stall) begin
				step_buzzer(bps_pkg::func_t'(func), bps_pkg::pattern_t'(pattern_request),
					now_ms, res);
				pin_forecast.push_back(res);
				words_in++;
				if (res.written)
					drives++;
			end
			if (out_valid && !out_stall) begin
				words_out++;
				if (pin_forecast.size() == 0) begin
					flag_mismatch("unexpected result word", 1, 0);
				end else begin
					exp = pin_forecast.pop_front();
					if (pin_written !== exp.written)
						flag_mismatch("pin_written", pin_written, exp.written);
					if (pin_level !== exp.level)
						flag_mismatch("pin_level", pin_level, exp.level);
				end
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (offering && in_took) begin
				void'(item_backlog.pop_front());
				offering = 1'b0;
				send_gap = pick_gap();
			end
			if (!offering) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (item_backlog.size() != 0) begin
					func <= item_backlog[0].op;
					pattern_request <= item_backlog[0].req;
					now_ms <= item_backlog[0].stamp;
					offering = 1'b1;
				end
			end
			in_valid <= offering;
		end
	end

	always @(negedge clk) begin : rx_side
		int roll;
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (hold_seen != hold_serial) begin
			hold_seen = hold_serial;
			hold_left = 59;
			out_stall <= 1'b1;
		end else if (run_left > 0) begin
			run_left--;
		end else begin
			roll = $urandom_range(0, 99);
			if (quiet || roll < 65) begin
				out_stall <= 1'b0;
				run_left = $urandom_range(0, 12);
			end else if (roll < 93) begin
				out_stall <= 1'b1;
				run_left = $urandom_range(0, 3);
			end else begin
				out_stall <= 1'b1;
				run_left = $urandom_range(10, 30);
			end
		end
	end

	task automatic push_item(input bps_pkg::func_t op, input bps_pkg::pattern_t req,
			input logic [31:0] stamp);
		buzz_item_t it;
		it.op = op;
		it.req = req;
		it.stamp = stamp;
		item_backlog.push_back(it);
	endtask

	task automatic push_set(input bps_pkg::pattern_t req);
		push_item(bps_pkg::FUNC_SET, req, $urandom);
	endtask

	task automatic push_update(input logic [31:0] stamp);
		push_item(bps_pkg::FUNC_UPDATE, bps_pkg::pattern_t'($urandom_range(0, 3)), stamp);
	endtask

	task automatic wait_drained();
		while (item_backlog.size() != 0 || offering || pin_forecast.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_polarity(input logic level);
		@(negedge clk);
		cfg_valid <= 1'b1;
		drive_polarity_high <= level;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic queue_random(input int n);
		int made;
		int kind;
		int k;
		int i;
		made = 0;
		while (made < n) begin
			kind = $urandom_range(0, 9);
			if (kind <= 6) begin
				push_set(bps_pkg::pattern_t'($urandom_range(0, 3)));
				made++;
				k = $urandom_range(2, 12);
				for (i = 0; i < k; i++) begin
					stim_ms = stim_ms + ms_step();
					push_update(stim_ms);
					made++;
				end
			end else if (kind == 7) begin
				k = $urandom_range(1, 4);
				for (i = 0; i < k; i++) begin
					push_item(bps_pkg::func_t'($urandom_range(0, 1)),
						bps_pkg::pattern_t'($urandom_range(0, 3)), $urandom);
					made++;
				end
			end else if (kind == 8) begin
				push_set(bps_pkg::PAT_OBSTACLE);
				push_set(bps_pkg::pattern_t'($urandom_range(0, 3)));
				push_set(bps_pkg::PAT_OBSTACLE);
				made += 3;
				k = $urandom_range(3, 8);
				for (i = 0; i < k; i++) begin
					stim_ms = stim_ms + ms_step();
					push_update(stim_ms);
					made++;
				end
			end else begin
				stim_ms = $urandom_range(0, 1) ? $urandom : 32'hFFFF_FFFF - $urandom_range(0, 3000);
			end
		end
	endtask

	initial begin
		logic [31:0] t;
		int          idle_wait;
		polarity = 1'b1;
		want_pat = bps_pkg::PAT_SILENT;
		obstacle_armed = 1'b0;
		tune_pat = bps_pkg::PAT_SILENT;
		tune_step = 2'd0;
		tune_t0 = 32'd0;
		pin_held = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed sequence: silent drives, start with a timestamp wrap, obstacle
		// latching and replay, fault and silent preemption, ignored fields.
		push_item(bps_pkg::FUNC_UPDATE, bps_pkg::PAT_FAULT, 32'd0);
		push_item(bps_pkg::FUNC_UPDATE, bps_pkg::PAT_SILENT, 32'hFFFF_FFFF);
		push_item(bps_pkg::FUNC_SET, bps_pkg::PAT_START, 32'hFFFF_FFFF);
		push_item(bps_pkg::FUNC_UPDATE, bps_pkg::PAT_FAULT, 32'hFFFF_FFF0);
		push_item(bps_pkg::FUNC_UPDATE, bps_pkg::PAT_OBSTACLE, 32'h0000_0050);
		push_item(bps_pkg::FUNC_UPDATE, bps_pkg::PAT_FAULT, 32'h0000_0054);
		t = 32'h0000_0054;
		push_item(bps_pkg::FUNC_UPDATE, bps_pkg::PAT_SILENT, t + 32'd1899);
		push_item(bps_pkg::FUNC_UPDATE, bps_pkg::PAT_START, t + 32'd1900);
		push_item(bps_pkg::FUNC_SET, bps_pkg::PAT_OBSTACLE, 32'd0);
		push_item(bps_pkg::FUNC_SET, bps_pkg::PAT_OBSTACLE, 32'hFFFF_FFFF);
		t = t + 32'd1905;
		push_item(bps_pkg::FUNC_UPDATE, bps_pkg::PAT_SILENT, t);
		push_item(bps_pkg::FUNC_UPDATE, bps_pkg::PAT_FAULT, t + 32'd99);
		push_item(bps_pkg::FUNC_UPDATE, bps_pkg::PAT_FAULT, t + 32'd100);
		push_item(bps_pkg::FUNC_UPDATE, bps_pkg::PAT_FAULT, t + 32'd200);
		push_item(bps_pkg::FUNC_UPDATE, bps_pkg::PAT_FAULT, t + 32'd300);
		push_item(bps_pkg::FUNC_UPDATE, bps_pkg::PAT_FAULT, t + 32'd999);
		push_item(bps_pkg::FUNC_UPDATE, bps_pkg::PAT_FAULT, t + 32'd1000);
		push_item(bps_pkg::FUNC_SET, bps_pkg::PAT_FAULT, 32'h1234_5678);
		push_item(bps_pkg::FUNC_UPDATE, bps_pkg::PAT_START, t + 32'd1010);
		push_item(bps_pkg::FUNC_UPDATE, bps_pkg::PAT_START, t + 32'd1210);
		push_item(bps_pkg::FUNC_SET, bps_pkg::PAT_START, 32'd0);
		push_item(bps_pkg::FUNC_UPDATE, bps_pkg::PAT_OBSTACLE, t + 32'd1300);
		push_item(bps_pkg::FUNC_SET, bps_pkg::PAT_OBSTACLE, 32'd7);
		push_item(bps_pkg::FUNC_SET, bps_pkg::PAT_SILENT, 32'hFFFF_FFFF);
		push_item(bps_pkg::FUNC_UPDATE, bps_pkg::PAT_START, t + 32'd1301);
		push_item(bps_pkg::FUNC_UPDATE, bps_pkg::PAT_OBSTACLE, t + 32'd5000);
		wait_drained();
		stim_ms = t + 32'd6000;

		set_polarity(1'b0);
		push_item(bps_pkg::FUNC_UPDATE, bps_pkg::PAT_SILENT, stim_ms);
		queue_random(90);
		wait_drained();

		// Receiver holds off while the sender offers back to back.
		set_polarity(1'b1);
		quiet = 1'b1;
		hold_serial++;
		queue_random(90);
		wait_drained();
		quiet = 1'b0;

		set_polarity(1'b0);
		queue_random(90);
		wait_drained();

		set_polarity(1'b1);
		queue_random(90);
		wait_drained();

		set_polarity(1'b0);
		queue_random(90);

		idle_wait = 0;
		while ((item_backlog.size() != 0 || offering || pin_forecast.size() != 0)
				&& idle_wait < 20000) begin
			@(negedge clk);
			idle_wait++;
		end
		repeat (8) @(negedge clk);
		if (pin_forecast.size() != 0)
			flag_mismatch("result words never delivered", 0, pin_forecast.size());

		$display("Run summary: %0d words in, %0d result words, %0d pin drives, %0d polarity writes.",
			words_in, words_out, drives, polarity_writes);
		$display("Covered all four patterns, wrapped timestamps, a long output hold and gap-free runs.");
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Timeout with %0d words in and %0d result words.", words_in, words_out);
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/bps_pkg.sv
rtl/bps_step.sv
rtl/buzzer_pattern_sequencer_core.sv
rtl/bps_checker.sv
sim/tb_buzzer_pattern_sequencer_core.sv
